// ===== rtl/ede_pkg.sv =====
package ede_pkg;

  // String store depth and derived widths
  localparam int MAX_LEN = 64;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int CELL_W  = $clog2(MAX_LEN + 2);
  localparam int SYM_W   = 8;
  localparam int MODE_W  = 2;
  localparam int DIST_W  = 7;
  localparam int DIST_MAX = 127;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECOND  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  typedef logic [1:0] bank_t;

  localparam bank_t BANK_A = 2'd0;
  localparam bank_t BANK_B = 2'd1;
  localparam bank_t BANK_C = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } ctl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              text_we_first;
    logic              text_we_second;
    logic [IDX_W-1:0]  text_waddr;
    logic [SYM_W-1:0]  text_wdata;
    logic              first_re;
    logic [IDX_W-1:0]  first_raddr;
    logic              issue;
    logic [POS_W-1:0]  col;
    bank_t             cur_bank;
    bank_t             one_bank;
    bank_t             two_bank;
    logic              row_we;
    bank_t             row_wbank;
    logic [POS_W-1:0]  row_waddr;
    logic [CELL_W-1:0] row_wdata;
    logic              row_start;
    logic              swap_ok;
    logic              out_load;
    logic              out_use_n2;
    logic [POS_W-1:0]  n2;
    logic              too_long;
  } ctl_cmd_t;

  // Clamp a table value to the result width
  function automatic logic [DIST_W-1:0] sat_dist(input logic [CELL_W-1:0] v);
    logic [DIST_W-1:0] r;
    if (32'(v) > 32'(DIST_MAX)) begin
      r = DIST_W'(DIST_MAX);
    end else begin
      r = DIST_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/ede_datapath.sv =====
module ede_datapath (
  input  logic             clk,
  input  logic             rst,
  input  ede_pkg::ctl_cmd_t cmd,
  output ede_pkg::rsp_t    rsp
);
  import ede_pkg::*;

  // String stores and the three rotating row buffers
  logic [SYM_W-1:0]  first_mem  [0:MAX_LEN-1];
  logic [SYM_W-1:0]  second_mem [0:MAX_LEN-1];
  logic [CELL_W-1:0] row_mem    [0:2][0:MAX_LEN];

  logic [SYM_W-1:0]  first_q;
  logic [SYM_W-1:0]  a_prev;
  logic [SYM_W-1:0]  second_q;
  logic [SYM_W-1:0]  b_prev;
  logic [CELL_W-1:0] one_q;
  logic [CELL_W-1:0] two_q;
  logic [CELL_W-1:0] one_prev;
  logic [CELL_W-1:0] left;
  logic              cell_valid;
  logic [POS_W-1:0]  cell_col;
  bank_t             cell_bank;

  logic [IDX_W-1:0]  second_raddr;
  logic [POS_W-1:0]  two_raddr;
  logic [CELL_W-1:0] cost;
  logic [CELL_W-1:0] best;
  logic [CELL_W-1:0] cand_ins;
  logic [CELL_W-1:0] cand_sub;
  logic [CELL_W-1:0] cand_swap;
  logic              swap_hit;

  // Column j reads second[j-1], one-back[j] and two-back[j-2]
  assign second_raddr = IDX_W'(cmd.col - POS_W'(1));
  assign two_raddr    = (cmd.col >= POS_W'(2)) ? (cmd.col - POS_W'(2)) : '0;

  // Text store writes and reads
  always_ff @(posedge clk) begin
    if (cmd.text_we_first) begin
      first_mem[cmd.text_waddr] <= cmd.text_wdata;
    end
    if (cmd.text_we_second) begin
      second_mem[cmd.text_waddr] <= cmd.text_wdata;
    end
    if (cmd.first_re) begin
      first_q <= first_mem[cmd.first_raddr];
    end
    if (cmd.issue) begin
      second_q <= second_mem[second_raddr];
    end
  end

  // Row buffer: one write port, two read ports
  always_ff @(posedge clk) begin
    if (cell_valid) begin
      row_mem[cell_bank][cell_col] <= best;
    end else if (cmd.row_we) begin
      row_mem[cmd.row_wbank][cmd.row_waddr] <= cmd.row_wdata;
    end
    if (cmd.issue) begin
      one_q <= row_mem[cmd.one_bank][cmd.col];
      two_q <= row_mem[cmd.two_bank][two_raddr];
    end
  end

  // Cell evaluation: minimum of delete, insert, substitute and swap
  always_comb begin
    cost      = (first_q == second_q) ? '0 : CELL_W'(1);
    cand_ins  = left + CELL_W'(1);
    cand_sub  = one_prev + cost;
    cand_swap = two_q + cost;
    swap_hit  = cmd.swap_ok && (cell_col > POS_W'(1)) &&
                (first_q == b_prev) && (a_prev == second_q);
    best = one_q + CELL_W'(1);
    if (cand_ins < best) begin
      best = cand_ins;
    end
    if (cand_sub < best) begin
      best = cand_sub;
    end
    if (swap_hit && (cand_swap < best)) begin
      best = cand_swap;
    end
  end

  // Compute stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      cell_valid <= cmd.issue;
    end
  end

  // Hold the running neighbours of the current cell
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      cell_col  <= cmd.col;
      cell_bank <= cmd.cur_bank;
    end
    if (cmd.row_start) begin
      a_prev   <= first_q;
      one_prev <= cmd.row_wdata - CELL_W'(1);
      left     <= cmd.row_wdata;
    end else if (cell_valid) begin
      left     <= best;
      one_prev <= one_q;
      b_prev   <= second_q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.distance <= cmd.out_use_n2 ? sat_dist(CELL_W'(cmd.n2)) : sat_dist(left);
      rsp.too_long <= cmd.too_long;
    end
  end

endmodule

// ===== rtl/ede_controller.sv =====
module ede_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ede_pkg::req_t     req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  logic              cfg_we,
  input  logic              cfg_data,
  output ede_pkg::ctl_cmd_t cmd
);
  import ede_pkg::*;

  ctl_state_t       state;
  ctl_state_t       state_next;
  logic [POS_W-1:0] first_count;
  logic [POS_W-1:0] second_count;
  logic             overflow_seen;
  logic             damerau_enable;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  bank_t            cur_bank;
  bank_t            one_bank;
  bank_t            two_bank;

  logic             accept;
  logic             out_free;
  logic             last_row;
  logic             rotate;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign last_row  = (row == first_count);

  // Next state and commands
  always_comb begin
    state_next         = state;
    rotate             = 1'b0;
    cmd                = '0;
    cmd.text_waddr     = (req.mode == MODE_FIRST) ? IDX_W'(first_count) : IDX_W'(second_count);
    cmd.text_wdata     = req.symbol;
    cmd.first_raddr    = IDX_W'(row - POS_W'(1));
    cmd.col            = col;
    cmd.cur_bank       = cur_bank;
    cmd.one_bank       = one_bank;
    cmd.two_bank       = two_bank;
    cmd.swap_ok        = damerau_enable && (row > POS_W'(1));
    cmd.n2             = second_count;
    cmd.too_long       = overflow_seen;
    cmd.out_use_n2     = (first_count == '0);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.mode)
            MODE_FIRST: begin
              cmd.text_we_first = (first_count < POS_W'(MAX_LEN));
            end
            MODE_SECOND: begin
              cmd.text_we_second = (second_count < POS_W'(MAX_LEN));
            end
            MODE_COMPUTE: begin
              state_next = ST_INIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INIT: begin
        // Border row: entry j holds j
        cmd.row_we    = 1'b1;
        cmd.row_wbank = one_bank;
        cmd.row_waddr = col;
        cmd.row_wdata = CELL_W'(col);
        if (col == second_count) begin
          state_next = (first_count == '0) ? ST_FINISH : ST_ROW;
        end
      end
      ST_ROW: begin
        // Row border cell and first-string byte for this row
        cmd.row_we    = 1'b1;
        cmd.row_wbank = cur_bank;
        cmd.row_waddr = '0;
        cmd.row_wdata = CELL_W'(row);
        cmd.row_start = 1'b1;
        cmd.first_re  = 1'b1;
        if (second_count == '0) begin
          rotate     = 1'b1;
          state_next = last_row ? ST_FINISH : ST_ROW;
        end else begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        if (col == second_count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        rotate     = 1'b1;
        state_next = last_row ? ST_FINISH : ST_ROW;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters, banks, flags and the result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count    <= '0;
      second_count   <= '0;
      overflow_seen  <= 1'b0;
      damerau_enable <= 1'b0;
      rsp_valid      <= 1'b0;
      row            <= '0;
      col            <= '0;
      cur_bank       <= BANK_A;
      one_bank       <= BANK_B;
      two_bank       <= BANK_C;
    end else begin
      if (cfg_we) begin
        damerau_enable <= cfg_data;
      end
      if (rsp_valid && rsp_ready && !cmd.out_load) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.text_we_first) begin
        first_count <= first_count + POS_W'(1);
      end
      if (cmd.text_we_second) begin
        second_count <= second_count + POS_W'(1);
      end
      // Drop bytes beyond the store and flag it
      if (accept && (((req.mode == MODE_FIRST) && !cmd.text_we_first) ||
                     ((req.mode == MODE_SECOND) && !cmd.text_we_second))) begin
        overflow_seen <= 1'b1;
      end
      if (rotate) begin
        two_bank <= one_bank;
        one_bank <= cur_bank;
        cur_bank <= two_bank;
      end
      unique case (state)
        ST_IDLE: begin
          col      <= '0;
          row      <= POS_W'(1);
          cur_bank <= BANK_A;
          one_bank <= BANK_B;
          two_bank <= BANK_C;
        end
        ST_INIT: begin
          col <= col + POS_W'(1);
        end
        ST_ROW: begin
          col <= POS_W'(1);
          if (second_count == '0) begin
            row <= row + POS_W'(1);
          end
        end
        ST_SWEEP: begin
          col <= col + POS_W'(1);
        end
        ST_DRAIN: begin
          row <= row + POS_W'(1);
        end
        ST_FINISH: begin
          if (out_free) begin
            rsp_valid     <= 1'b1;
            first_count   <= '0;
            second_count  <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/edit_distance_engine.sv =====
// Byte appends (mode 0 or 1): one beat per cycle, back to back, while the engine is idle; no result.
// Compute (mode 2): writes the border row, then per row a border step, one cell
// a cycle and a drain step (only the border step with an empty second string);
// the result loads once the output is free, so a held result delays that load.
// Reset (rst, synchronous) empties both strings, clears the overflow flag and
// damerau_enable; string and row stores keep their contents until written.
module edit_distance_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ede_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ede_pkg::rsp_t  rsp,
  input  logic           cfg_we,
  input  logic           cfg_data
);
  import ede_pkg::*;

  ctl_cmd_t cmd;

  ede_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd)
  );

  ede_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule

// ===== tb/sv/edit_distance_checker.sv =====
module edit_distance_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  ede_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  ede_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic          cfg_data,
  output int            mismatches,
  output int            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import ede_pkg::*;

  // Shadow copy of the two string stores and the swap setting
  logic [SYM_W-1:0] first_bytes [MAX_LEN];
  logic [SYM_W-1:0] second_bytes [MAX_LEN];
  int               first_len;
  int               second_len;
  logic             dropped;
  logic             swap_on;
  rsp_t             distance_q [$];

  // Sweep the table over three rows; adjacent swaps count once when enabled
  function automatic logic [DIST_W-1:0] edit_cost();
    int two_back [MAX_LEN+1];
    int one_back [MAX_LEN+1];
    int now_row [MAX_LEN+1];
    int best;
    int sub;
    logic [SYM_W-1:0] a;
    logic [SYM_W-1:0] b;
    for (int j = 0; j <= MAX_LEN; j++) begin
      one_back[j] = j;
      two_back[j] = 0;
      now_row[j]  = 0;
    end
    for (int i = 1; i <= first_len; i++) begin
      now_row[0] = i;
      for (int j = 1; j <= second_len; j++) begin
        a    = first_bytes[i-1];
        b    = second_bytes[j-1];
        sub  = (a == b) ? 0 : 1;
        best = one_back[j] + 1;
        if (now_row[j-1] + 1 < best) best = now_row[j-1] + 1;
        if (one_back[j-1] + sub < best) best = one_back[j-1] + sub;
        if (swap_on && i > 1 && j > 1 && a == second_bytes[j-2] &&
            first_bytes[i-2] == b && two_back[j-2] + sub < best) begin
          best = two_back[j-2] + sub;
        end
        now_row[j] = best;
      end
      two_back = one_back;
      one_back = now_row;
    end
    if (one_back[second_len] > DIST_MAX) return DIST_W'(DIST_MAX);
    return DIST_W'(one_back[second_len]);
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      first_len  = 0;
      second_len = 0;
      dropped    = 1'b0;
      swap_on    = 1'b0;
      distance_q.delete();
    end else begin
      // Compare a result beat with the oldest pending distance
      if (rsp_valid && rsp_ready) begin
        if (distance_q.size() == 0) begin
          $error("unexpected result beat: distance %0d too_long %0b",
                 rsp.distance, rsp.too_long);
          mismatches++;
        end else begin
          want = distance_q.pop_front();
          if (rsp.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, rsp.distance);
            mismatches++;
          end
          if (rsp.too_long !== want.too_long) begin
            $error("too_long: expected %0b, actual %0b", want.too_long, rsp.too_long);
            mismatches++;
          end
        end
      end

      // Advance the shadow stores on each request beat
      if (req_valid && req_ready) begin
        case (req.mode)
          MODE_FIRST: begin
            if (first_len < MAX_LEN) begin
              first_bytes[first_len] = req.symbol;
              first_len++;
            end else begin
              dropped = 1'b1;
            end
          end
          MODE_SECOND: begin
            if (second_len < MAX_LEN) begin
              second_bytes[second_len] = req.symbol;
              second_len++;
            end else begin
              dropped = 1'b1;
            end
          end
          MODE_COMPUTE: begin
            want.distance = edit_cost();
            want.too_long = dropped;
            distance_q.push_back(want);
            first_len  = 0;
            second_len = 0;
            dropped    = 1'b0;
          end
          default: begin
          end
        endcase
      end

      if (cfg_we) swap_on = cfg_data;
    end
    outstanding = distance_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ede_pkg::*;

  // Mode that the engine must ignore
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_we    = 1'b0;
  logic cfg_data  = 1'b0;
  int   mismatches;
  int   outstanding;

  bit   calm      = 1'b0;
  int   gap_pct   = 20;
  int   stall_pct = 10;
  int   sent      = 0;

  always #2 clk = ~clk;

  edit_distance_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  edit_distance_checker dist_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Present one request beat, with an optional idle burst first
  task automatic send_beat(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{mode: m, symbol: s};
    do @(posedge clk); while (!req_ready);
  endtask

  // Drop valid, drain every pending distance, then write the swap setting
  task automatic set_swap(input logic on);
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= on;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Load a pair of strings in random interleave, then ask for the distance
  task automatic run_pair();
    logic [SYM_W-1:0] first_seq [$];
    logic [SYM_W-1:0] second_seq [$];
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] hold;
    int n1;
    int n2;
    int roll;
    int spread;
    int pos;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      n1 = $urandom_range(0, 8);
      n2 = $urandom_range(0, 8);
    end else if (roll < 94) begin
      n1 = $urandom_range(9, 24);
      n2 = $urandom_range(9, 24);
    end else if (roll < 98) begin
      n1 = $urandom_range(25, MAX_LEN);
      n2 = $urandom_range(25, MAX_LEN);
    end else begin
      n1 = $urandom_range(0, MAX_LEN + 6);
      n2 = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
      if ($urandom_range(0, 1) == 1) begin
        pos = n1;
        n1  = n2;
        n2  = pos;
      end
    end

    // Narrow alphabets give matches and swaps; a wide one gives all bytes
    base   = SYM_W'($urandom);
    spread = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
    repeat (n1) first_seq.push_back(base ^ SYM_W'($urandom_range(0, spread - 1)));

    if ($urandom_range(0, 2) != 0) begin
      // Derive the second string from the first by a few edits
      second_seq = first_seq;
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 3))
          0: begin
            if (second_seq.size() >= 2) begin
              pos = $urandom_range(0, second_seq.size() - 2);
              hold = second_seq[pos];
              second_seq[pos]   = second_seq[pos+1];
              second_seq[pos+1] = hold;
            end
          end
          1: begin
            if (second_seq.size() > 0) begin
              pos = $urandom_range(0, second_seq.size() - 1);
              second_seq[pos] = base ^ SYM_W'($urandom_range(0, spread - 1));
            end
          end
          2: begin
            if (second_seq.size() > 0) begin
              second_seq.delete($urandom_range(0, second_seq.size() - 1));
            end
          end
          default: begin
            pos = $urandom_range(0, second_seq.size());
            second_seq.insert(pos, base ^ SYM_W'($urandom_range(0, spread - 1)));
          end
        endcase
      end
    end else begin
      repeat (n2) second_seq.push_back(base ^ SYM_W'($urandom_range(0, spread - 1)));
    end

    while (first_seq.size() + second_seq.size() > 0) begin
      if ($urandom_range(0, 24) == 0) send_beat(MODE_SPARE, SYM_W'($urandom));
      if (second_seq.size() == 0 || (first_seq.size() > 0 && $urandom_range(0, 1) == 1)) begin
        send_beat(MODE_FIRST, first_seq.pop_front());
      end else begin
        send_beat(MODE_SECOND, second_seq.pop_front());
      end
      sent++;
    end
    send_beat(MODE_COMPUTE, SYM_W'($urandom));
    sent++;
  endtask

  // Hold off the result side in short random bursts
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 4);
        rsp_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  initial begin
    int quota;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Both strings empty; symbol ignored on compute
    send_beat(MODE_COMPUTE, 8'hFF);
    // Empty second string, extreme bytes
    send_beat(MODE_FIRST, 8'h00);
    send_beat(MODE_FIRST, 8'hFF);
    send_beat(MODE_COMPUTE, 8'h00);
    // Spare mode is dropped; empty first string
    send_beat(MODE_SPARE, 8'h5A);
    send_beat(MODE_SECOND, 8'hA5);
    send_beat(MODE_COMPUTE, 8'hA5);
    // Adjacent swap costs two without the swap rule
    send_beat(MODE_FIRST, 8'h61);
    send_beat(MODE_FIRST, 8'h62);
    send_beat(MODE_SECOND, 8'h62);
    send_beat(MODE_SECOND, 8'h61);
    send_beat(MODE_COMPUTE, 8'h00);

    // Same swap costs one with the swap rule
    set_swap(1'b1);
    send_beat(MODE_FIRST, 8'h61);
    send_beat(MODE_SECOND, 8'h62);
    send_beat(MODE_FIRST, 8'h62);
    send_beat(MODE_SECOND, 8'h61);
    send_beat(MODE_COMPUTE, 8'hFF);
    // Equal strings, then a swap inside a longer string
    send_beat(MODE_FIRST, 8'h7E);
    send_beat(MODE_SECOND, 8'h7E);
    send_beat(MODE_COMPUTE, 8'h00);
    send_beat(MODE_FIRST, 8'h01);
    send_beat(MODE_FIRST, 8'h80);
    send_beat(MODE_FIRST, 8'h02);
    send_beat(MODE_SECOND, 8'h01);
    send_beat(MODE_SECOND, 8'h02);
    send_beat(MODE_SECOND, 8'h80);
    send_beat(MODE_COMPUTE, 8'h00);
    sent = 27;

    // Overfill the first store against a full, disjoint second store
    repeat (MAX_LEN + 2) send_beat(MODE_FIRST, 8'h00);
    repeat (MAX_LEN) send_beat(MODE_SECOND, 8'hFF);
    send_beat(MODE_COMPUTE, 8'h00);
    // Overfill the second store only
    repeat (3) send_beat(MODE_FIRST, SYM_W'($urandom));
    repeat (MAX_LEN + 1) send_beat(MODE_SECOND, SYM_W'($urandom));
    send_beat(MODE_COMPUTE, 8'h00);
    sent += 3 * MAX_LEN + 8;

    // Random pairs over alternating swap settings and idling levels
    for (int p = 0; p < 6; p++) begin
      set_swap(p % 2 == 0);
      gap_pct   = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
      stall_pct = (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 10 : 30);
      quota = sent + 255;
      while (sent < quota) begin
        if (sent >= 1600) calm = 1'b1;
        run_pair();
      end
    end

    // Drain and settle
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== edit_distance_engine.f =====
rtl/ede_pkg.sv
rtl/ede_datapath.sv
rtl/ede_controller.sv
rtl/edit_distance_engine.sv
tb/sv/edit_distance_checker.sv
tb/sv/tb.sv
